// File: rtl/core/rgb_frame_effects_mirror_assert.svh
// Assertion macros shared by the frame effects block.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef RGB_FRAME_EFFECTS_MIRROR_ASSERT_SVH
`define RGB_FRAME_EFFECTS_MIRROR_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define RFEM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rfem assertion failed");

// The consequence must hold in the cycle after the condition.
`define RFEM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rfem assertion failed");

`endif

// File: rtl/core/rfem_pkg.sv
package rfem_pkg;

    // Frame geometry.
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int POS_W       = $clog2(STORE_DEPTH);
    localparam int TOT_W       = $clog2(STORE_DEPTH + 1);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 7;
    localparam int CNT_W       = $clog2(POS_W);

    // Pixel format.
    localparam int CH_W = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam logic [CH_W-1:0] FULL_SCALE   = 8'd255;
    localparam logic [CH_W-1:0] CONTRAST_MID = FULL_SCALE / 2;

    // Division of the channel sum by three as a multiply by a reciprocal.
    // The result is exact for sums below 2048.
    localparam int SUM_W     = CH_W + 2;
    localparam int AVG_MUL_W = 10;
    localparam int AVG_SHIFT = 11;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL = 10'd683;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_GRAYSCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEGATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLATTEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_H    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_V    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic calc;
        logic load;
        logic norm;
        logic div_step;
        logic addr;
        logic mem_rd;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic need_div;
        logic div_last;
    } ctrl_stat_t;

endpackage

// File: rtl/core/rfem_ctrl.sv
`include "rgb_frame_effects_mirror_assert.svh"

module rfem_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  rfem_pkg::ctrl_stat_t  stat,
    output rfem_pkg::ctrl_cmd_t   cmd
);
    import rfem_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_LOAD,
        ST_CHECK,
        ST_DIV,
        ST_ADDR,
        ST_MEM,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

    // Decode the datapath commands from the current state.
    always_comb begin
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        cmd.calc     = (state_reg == ST_CALC);
        cmd.load     = (state_reg == ST_LOAD);
        cmd.norm     = (state_reg == ST_CHECK);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.addr     = (state_reg == ST_ADDR);
        cmd.mem_rd   = (state_reg == ST_MEM);
    end

    // Sequencer with registered handshake outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_CALC;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_CALC: begin
                    state_reg <= stat.is_read ? ST_CHECK : ST_LOAD;
                end
                ST_LOAD: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
                ST_CHECK: begin
                    state_reg <= stat.need_div ? ST_DIV : ST_ADDR;
                end
                ST_DIV: begin
                    if (stat.div_last) begin
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    state_reg <= ST_MEM;
                end
                ST_MEM: begin
                    state_reg   <= ST_OUT;
                    m_valid_reg <= 1'b1;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b0;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // The block never offers a result while it can take a new word.
    `RFEM_ASSERT_NOW(a_ready_excludes_valid, aclk, aresetn, s_ready_reg, !m_valid_reg)
    // An accepted word always starts the shared calculation step.
    `RFEM_ASSERT_NEXT(a_accept_starts_calc, aclk, aresetn, s_valid && s_ready_reg, !s_ready_reg && state_reg == ST_CALC)
    // A result appears only after the frame store was read.
    `RFEM_ASSERT_NOW(a_valid_after_mem, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_MEM)
    // The divider hands over to address generation on its final step.
    `RFEM_ASSERT_NEXT(a_div_exit, aclk, aresetn, state_reg == ST_DIV && stat.div_last, state_reg == ST_ADDR)

endmodule

// File: rtl/core/rfem_datapath.sv
module rfem_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rfem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfem_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_cmd,
    input  logic [rfem_pkg::CH_W-1:0]         s_red_in,
    input  logic [rfem_pkg::CH_W-1:0]         s_green_in,
    input  logic [rfem_pkg::CH_W-1:0]         s_blue_in,
    input  rfem_pkg::ctrl_cmd_t               cmd,
    output rfem_pkg::ctrl_stat_t              stat,
    output logic [rfem_pkg::CH_W-1:0]         m_red_out,
    output logic [rfem_pkg::CH_W-1:0]         m_green_out,
    output logic [rfem_pkg::CH_W-1:0]         m_blue_out,
    output logic                              m_last_pixel
);
    import rfem_pkg::*;

    // Configuration registers.
    logic             gray_reg;
    logic [2:0]       negate_reg;
    logic [2:0]       flatten_reg;
    logic             contrast_reg;
    logic             mirror_h_reg;
    logic             mirror_v_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // Captured word and per-item intermediates.
    logic             cmd_reg;
    logic [CH_W-1:0]  red_reg;
    logic [CH_W-1:0]  green_reg;
    logic [CH_W-1:0]  blue_reg;
    logic [TOT_W-1:0] total_reg;
    logic [CH_W-1:0]  avg_reg;

    // Positions. The read position is also kept as a row and column.
    logic [POS_W-1:0] load_pos_reg;
    logic [POS_W-1:0] read_pos_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             stale_reg;

    // Restoring divider that rebuilds row and column after a width change.
    logic [DIM_W-1:0] div_rem_reg;
    logic [POS_W-1:0] div_quo_reg;
    logic [CNT_W-1:0] div_cnt_reg;

    // Read address, end-of-frame flag and store output.
    logic [POS_W-1:0] addr_reg;
    logic             last_reg;
    logic [PIX_W-1:0] rd_data_reg;

    logic [PIX_W-1:0] frame_mem [STORE_DEPTH];

    logic [DIM_W-1:0]          w_eff;
    logic [DIM_W-1:0]          h_eff;
    logic [2*DIM_W-1:0]        prod_wh;
    logic [SUM_W-1:0]          ch_sum;
    logic [SUM_W+AVG_MUL_W-1:0] avg_prod;
    logic [CH_W-1:0]           ch_fx [3];
    logic [PIX_W-1:0]          pix_fx;
    logic [POS_W-1:0]          ld_idx;
    logic [TOT_W-1:0]          ld_inc;
    logic [POS_W-1:0]          load_pos_next;
    logic                      rd_wrap;
    logic [DIM_W:0]            div_trial;
    logic [DIM_W:0]            div_diff;
    logic                      div_ge;
    logic [DIM_W-1:0]          div_rem_next;
    logic [POS_W-1:0]          div_quo_next;
    logic                      div_last;
    logic [DIM_W-1:0]          col_ext;
    logic [DIM_W-1:0]          row_ext;
    logic [DIM_W-1:0]          col_m;
    logic [DIM_W-1:0]          row_m;
    logic [2*DIM_W-1:0]        rd_prod;
    logic [2*DIM_W-1:0]        rd_sum;
    logic [TOT_W-1:0]          rd_inc;
    logic                      rd_end;
    logic [DIM_W-1:0]          col_inc;
    logic [POS_W-1:0]          read_pos_next;
    logic [ROW_W-1:0]          row_next;
    logic [COL_W-1:0]          col_next;

    // Frame size: zero counts as one, values above the maximum saturate.
    always_comb begin
        w_eff = width_reg;
        if (width_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (height_reg > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
    end

    assign prod_wh = w_eff * h_eff;

    // Grayscale average of the captured pixel.
    assign ch_sum   = SUM_W'(red_reg) + SUM_W'(green_reg) + SUM_W'(blue_reg);
    assign avg_prod = ch_sum * AVG_MUL;

    // Point effects in order: grayscale, negate, flatten, contrast.
    always_comb begin
        ch_fx[0] = gray_reg ? avg_reg : red_reg;
        ch_fx[1] = gray_reg ? avg_reg : green_reg;
        ch_fx[2] = gray_reg ? avg_reg : blue_reg;
        for (int k = 0; k < 3; k++) begin
            if (negate_reg[k]) begin
                ch_fx[k] = FULL_SCALE - ch_fx[k];
            end
            if (flatten_reg[k]) begin
                ch_fx[k] = '0;
            end
            if (contrast_reg) begin
                ch_fx[k] = (ch_fx[k] > CONTRAST_MID) ? FULL_SCALE : '0;
            end
        end
    end

    assign pix_fx = {ch_fx[0], ch_fx[1], ch_fx[2]};

    // Load position with restart after a size change and wrap at frame end.
    assign ld_idx        = ({1'b0, load_pos_reg} >= total_reg) ? '0 : load_pos_reg;
    assign ld_inc        = {1'b0, ld_idx} + TOT_W'(1);
    assign load_pos_next = (ld_inc >= total_reg) ? '0 : ld_inc[POS_W-1:0];

    assign rd_wrap = ({1'b0, read_pos_reg} >= total_reg);

    // One quotient bit per step.
    assign div_trial    = {div_rem_reg, div_quo_reg[POS_W-1]};
    assign div_diff     = div_trial - {1'b0, w_eff};
    assign div_ge       = (div_trial >= {1'b0, w_eff});
    assign div_rem_next = div_ge ? div_diff[DIM_W-1:0] : div_trial[DIM_W-1:0];
    assign div_quo_next = {div_quo_reg[POS_W-2:0], div_ge};
    assign div_last     = (div_cnt_reg == CNT_W'(POS_W - 1));

    // Mirrored store address for the current read position.
    assign col_ext = DIM_W'(col_reg);
    assign row_ext = DIM_W'(row_reg);
    assign col_m   = mirror_h_reg ? (w_eff - DIM_W'(1) - col_ext) : col_ext;
    assign row_m   = mirror_v_reg ? (h_eff - DIM_W'(1) - row_ext) : row_ext;
    assign rd_prod = row_m * w_eff;
    assign rd_sum  = rd_prod + (2*DIM_W)'(col_m);

    // Advance of the read position in raster order.
    always_comb begin
        rd_inc        = {1'b0, read_pos_reg} + TOT_W'(1);
        rd_end        = (rd_inc >= total_reg);
        col_inc       = col_ext + DIM_W'(1);
        read_pos_next = rd_inc[POS_W-1:0];
        row_next      = row_reg;
        col_next      = col_inc[COL_W-1:0];
        if (rd_end) begin
            read_pos_next = '0;
            row_next      = '0;
            col_next      = '0;
        end else if (col_inc == w_eff) begin
            row_next = row_reg + ROW_W'(1);
            col_next = '0;
        end
    end

    assign stat.is_read  = cmd_reg;
    assign stat.need_div = stale_reg && !rd_wrap;
    assign stat.div_last = div_last;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_reg     <= 1'b0;
            negate_reg   <= '0;
            flatten_reg  <= '0;
            contrast_reg <= 1'b0;
            mirror_h_reg <= 1'b0;
            mirror_v_reg <= 1'b0;
            width_reg    <= DIM_W'(MAX_WIDTH);
            height_reg   <= DIM_W'(MAX_HEIGHT);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRAYSCALE:    gray_reg     <= cfg_data[0];
                REG_NEGATE:       negate_reg   <= cfg_data[2:0];
                REG_FLATTEN:      flatten_reg  <= cfg_data[2:0];
                REG_CONTRAST:     contrast_reg <= cfg_data[0];
                REG_MIRROR_H:     mirror_h_reg <= cfg_data[0];
                REG_MIRROR_V:     mirror_v_reg <= cfg_data[0];
                REG_IMAGE_WIDTH:  width_reg    <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Load and read positions. A width change marks row and column as stale.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg <= '0;
            read_pos_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            stale_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                load_pos_reg <= load_pos_next;
            end
            if (cmd.norm && rd_wrap) begin
                read_pos_reg <= '0;
                row_reg      <= '0;
                col_reg      <= '0;
                stale_reg    <= 1'b0;
            end
            if (cmd.div_step && div_last) begin
                row_reg   <= div_quo_next[ROW_W-1:0];
                col_reg   <= div_rem_next[COL_W-1:0];
                stale_reg <= 1'b0;
            end
            if (cmd.addr) begin
                read_pos_reg <= read_pos_next;
                row_reg      <= row_next;
                col_reg      <= col_next;
            end
            if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
                stale_reg <= 1'b1;
            end
        end
    end

    // Item payload and intermediate results.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= s_cmd;
            red_reg   <= s_red_in;
            green_reg <= s_green_in;
            blue_reg  <= s_blue_in;
        end
        if (cmd.calc) begin
            total_reg <= prod_wh[TOT_W-1:0];
            avg_reg   <= avg_prod[AVG_SHIFT +: CH_W];
        end
        if (cmd.norm) begin
            div_rem_reg <= '0;
            div_quo_reg <= read_pos_reg;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
            div_cnt_reg <= div_cnt_reg + CNT_W'(1);
        end
        if (cmd.addr) begin
            addr_reg <= rd_sum[POS_W-1:0];
            last_reg <= (rd_inc == total_reg);
        end
    end

    // Frame store: one write port for loads, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            frame_mem[ld_idx] <= pix_fx;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= frame_mem[addr_reg];
        end
    end

    assign m_red_out    = rd_data_reg[2*CH_W +: CH_W];
    assign m_green_out  = rd_data_reg[CH_W +: CH_W];
    assign m_blue_out   = rd_data_reg[0 +: CH_W];
    assign m_last_pixel = last_reg;

endmodule

// File: rtl/core/rgb_frame_effects_mirror.sv
// Channel   Direction  Handshake          Word
// s_        in         s_valid/s_ready    s_cmd, s_red_in, s_green_in, s_blue_in
// m_        out        m_valid/m_ready    m_red_out, m_green_out, m_blue_out, m_last_pixel
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// A load word passes through the calculate and load states before the next word is accepted.
// A read word passes through the calculate, check, address and store-read states before
// its result is shown, and is done when m_ready is high.
// The first read after an image_width write also runs the bit-serial divider
// that rebuilds row and column from the read position, unless that position restarts at zero.
// Reset is synchronous and active low; the frame store is not cleared.
// While a result waits on m_ready the block holds it and accepts no new word.
module rgb_frame_effects_mirror (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [rfem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [rfem_pkg::CH_W-1:0]        s_red_in,
    input  logic [rfem_pkg::CH_W-1:0]        s_green_in,
    input  logic [rfem_pkg::CH_W-1:0]        s_blue_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rfem_pkg::CH_W-1:0]        m_red_out,
    output logic [rfem_pkg::CH_W-1:0]        m_green_out,
    output logic [rfem_pkg::CH_W-1:0]        m_blue_out,
    output logic                             m_last_pixel
);
    import rfem_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // Sequencer.
    rfem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Effects, positions, divider and frame store.
    rfem_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_cmd        (s_cmd),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .cmd          (cmd),
        .stat         (stat),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_last_pixel (m_last_pixel)
    );

endmodule

// File: tb/tb_rgb_frame_effects_mirror.sv
`timescale 1ns / 1ps

module tb_rgb_frame_effects_mirror;
    import rfem_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 1150;
    localparam int QUIET_AFTER  = 1000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int FRAME_CAP    = 48;
    localparam int CH_TOP       = 255;
    localparam int CH_MID       = 127;

    typedef enum logic {CMD_LOAD = 1'b0, CMD_READ = 1'b1} pixel_cmd_t;
    typedef enum logic {ROW_REG = 1'b0, ROW_WORD = 1'b1} row_kind_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } out_pixel_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        pixel_cmd_t            cmd;
        logic [CH_W-1:0]       red;
        logic [CH_W-1:0]       green;
        logic [CH_W-1:0]       blue;
        logic                  fixed;
        logic [CH_W-1:0]       want_red;
        logic [CH_W-1:0]       want_green;
        logic [CH_W-1:0]       want_blue;
        logic                  want_last;
    } script_row_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_cmd        = 1'b0;
    logic [CH_W-1:0]       s_red_in     = '0;
    logic [CH_W-1:0]       s_green_in   = '0;
    logic [CH_W-1:0]       s_blue_in    = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [CH_W-1:0]       m_red_out;
    logic [CH_W-1:0]       m_green_out;
    logic [CH_W-1:0]       m_blue_out;
    logic                  m_last_pixel;

    // Shadow copy of the block's registers and frame store.
    bit                    gray_on;
    bit [2:0]              negate_mask;
    bit [2:0]              flatten_mask;
    bit                    contrast_on;
    bit                    flip_cols;
    bit                    flip_rows;
    bit [DIM_W-1:0]        width_reg  = 7'd64;
    bit [DIM_W-1:0]        height_reg = 7'd64;
    logic [PIX_W-1:0]      frame_mem [STORE_DEPTH];
    bit                    frame_written [STORE_DEPTH];
    int                    load_idx;
    int                    read_idx;

    out_pixel_t            pending_pixels [$];
    script_row_t           directed_steps [$];
    int                    mismatches   = 0;
    int                    cycle_count  = 0;
    int                    random_words = 0;
    int                    tx_gap_pct   = 10;
    bit                    quiet        = 1'b0;
    bit                    hold_sink    = 1'b0;
    bit                    drained      = 1'b1;

    rgb_frame_effects_mirror u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_last_pixel (m_last_pixel)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Zero and oversized dimensions are pulled into the legal range.
    function automatic int dim_of(input bit [DIM_W-1:0] v, input int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic int frame_total();
        return dim_of(width_reg, MAX_WIDTH) * dim_of(height_reg, MAX_HEIGHT);
    endfunction

    // Point effects in order: grayscale, then per channel negate, flatten, contrast.
    function automatic logic [PIX_W-1:0] shade(input logic [CH_W-1:0] r,
                                               input logic [CH_W-1:0] g,
                                               input logic [CH_W-1:0] b);
        int ch [3];
        int avg;
        ch[0] = r;
        ch[1] = g;
        ch[2] = b;
        if (gray_on) begin
            avg = (ch[0] + ch[1] + ch[2]) / 3;
            ch[0] = avg;
            ch[1] = avg;
            ch[2] = avg;
        end
        for (int k = 0; k < 3; k++) begin
            if (negate_mask[k]) ch[k] = CH_TOP - ch[k];
            if (flatten_mask[k]) ch[k] = 0;
            if (contrast_on) ch[k] = (ch[k] > CH_MID) ? CH_TOP : 0;
        end
        return {ch[0][CH_W-1:0], ch[1][CH_W-1:0], ch[2][CH_W-1:0]};
    endfunction

    // Store address that the next read word will fetch, after mirroring.
    function automatic int mirrored_addr();
        int w;
        int h;
        int idx;
        int row;
        int col;
        w = dim_of(width_reg, MAX_WIDTH);
        h = dim_of(height_reg, MAX_HEIGHT);
        idx = (read_idx >= w * h) ? 0 : read_idx;
        row = idx / w;
        col = idx % w;
        if (flip_cols) col = w - 1 - col;
        if (flip_rows) row = h - 1 - row;
        return row * w + col;
    endfunction

    task automatic predict_word(input pixel_cmd_t cmd, input logic [CH_W-1:0] r,
                                input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                                output bit produced, output out_pixel_t pix);
        int total;
        int idx;
        int addr;
        logic [PIX_W-1:0] word;
        total = frame_total();
        produced = 1'b0;
        pix = '0;
        if (cmd == CMD_LOAD) begin
            idx = (load_idx >= total) ? 0 : load_idx;
            frame_mem[POS_W'(idx)] = shade(r, g, b);
            frame_written[POS_W'(idx)] = 1'b1;
            load_idx = (idx + 1 >= total) ? 0 : idx + 1;
        end else begin
            idx = (read_idx >= total) ? 0 : read_idx;
            addr = mirrored_addr();
            word = frame_mem[POS_W'(addr)];
            pix.red = word[23:16];
            pix.green = word[15:8];
            pix.blue = word[7:0];
            pix.last = (idx + 1 == total);
            read_idx = (idx + 1 >= total) ? 0 : idx + 1;
            produced = 1'b1;
        end
    endtask

    // Offer one word, hold it until it is taken, then record what it should return.
    task automatic send_word(input pixel_cmd_t cmd, input logic [CH_W-1:0] r,
                             input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                             input bit fixed, input out_pixel_t fixed_pix);
        int gap;
        bit produced;
        out_pixel_t pix;
        if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
        drained = 1'b0;
        predict_word(cmd, r, g, b, produced, pix);
        if (produced) begin
            pending_pixels.insert(pending_pixels.size(), fixed ? fixed_pix : pix);
        end
    endtask

    // Let every result drain, then give a trailing load word time to finish.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        drained = 1'b1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        case (idx)
            REG_GRAYSCALE:    gray_on = value[0];
            REG_NEGATE:       negate_mask = value[2:0];
            REG_FLATTEN:      flatten_mask = value[2:0];
            REG_CONTRAST:     contrast_on = value[0];
            REG_MIRROR_H:     flip_cols = value[0];
            REG_MIRROR_V:     flip_rows = value[0];
            REG_IMAGE_WIDTH:  width_reg = value;
            REG_IMAGE_HEIGHT: height_reg = value;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 8'd255;
            2: return 8'd127;
            3: return 8'd128;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 11))
            0: return 7'd0;
            1: return 7'd64;
            2: return 7'd127;
            default: return DIM_W'($urandom_range(1, 6));
        endcase
    endfunction

    // A read word that would fetch a never-loaded entry is turned into a load word.
    task automatic random_word(input pixel_cmd_t want);
        pixel_cmd_t cmd;
        cmd = want;
        if (cmd == CMD_READ && !frame_written[POS_W'(mirrored_addr())]) cmd = CMD_LOAD;
        send_word(cmd, pick_channel(), pick_channel(), pick_channel(), 1'b0, '0);
        random_words++;
        if (random_words >= QUIET_AFTER) quiet = 1'b1;
    endtask

    // Append one row to the directed table.
    function automatic void add_step(input script_row_t row);
        directed_steps.insert(directed_steps.size(), row);
    endfunction

    function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        script_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic script_row_t word_row(input pixel_cmd_t cmd, input logic [CH_W-1:0] r,
                                             input logic [CH_W-1:0] g,
                                             input logic [CH_W-1:0] b);
        script_row_t row;
        row = '0;
        row.kind = ROW_WORD;
        row.cmd = cmd;
        row.red = r;
        row.green = g;
        row.blue = b;
        return row;
    endfunction

    // A read row whose result is known without working it out.
    function automatic script_row_t known_row(input logic [CH_W-1:0] er,
                                              input logic [CH_W-1:0] eg,
                                              input logic [CH_W-1:0] eb, input logic el);
        script_row_t row;
        row = word_row(CMD_READ, 8'h5A, 8'hA5, 8'hC3);
        row.fixed = 1'b1;
        row.want_red = er;
        row.want_green = eg;
        row.want_blue = eb;
        row.want_last = el;
        return row;
    endfunction

    // Receiver: random stalls, long ready stretches, and one long hold-off on request.
    initial begin
        int n;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_sink = 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 7) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(posedge aclk);
            end else if ($urandom_range(0, 99) < 3) begin
                m_ready <= 1'b1;
                n = $urandom_range(20, 100);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare every result word against the oldest expected pixel.
    always @(posedge aclk) begin : check_results
        out_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result word: red_out %0d green_out %0d blue_out %0d",
                       m_red_out, m_green_out, m_blue_out);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_red_out !== want.red) begin
                    $error("red_out: expected %0d, actual %0d", want.red, m_red_out);
                    mismatches++;
                end
                if (m_green_out !== want.green) begin
                    $error("green_out: expected %0d, actual %0d", want.green, m_green_out);
                    mismatches++;
                end
                if (m_blue_out !== want.blue) begin
                    $error("blue_out: expected %0d, actual %0d", want.blue, m_blue_out);
                    mismatches++;
                end
                if (m_last_pixel !== want.last) begin
                    $error("last_pixel: expected %0d, actual %0d", want.last, m_last_pixel);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("rgb_frame_effects_mirror: mismatch");
        $finish;
    end

    initial begin
        int total;
        int n;
        int phase;
        out_pixel_t fixed_pix;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;

        // Directed part: reset state, dimension clamping, each effect, mirrored readout.
        add_step(word_row(CMD_LOAD, 8'd255, 8'd0, 8'd128));
        add_step(known_row(8'd255, 8'd0, 8'd128, 1'b0));
        add_step(reg_row(REG_IMAGE_WIDTH, 7'd0));
        add_step(reg_row(REG_IMAGE_HEIGHT, 7'd0));
        add_step(word_row(CMD_LOAD, 8'd0, 8'd255, 8'd127));
        add_step(known_row(8'd0, 8'd255, 8'd127, 1'b1));
        add_step(reg_row(REG_GRAYSCALE, 7'd1));
        add_step(word_row(CMD_LOAD, 8'd255, 8'd255, 8'd255));
        add_step(known_row(8'd255, 8'd255, 8'd255, 1'b1));
        add_step(word_row(CMD_LOAD, 8'd255, 8'd254, 8'd0));
        add_step(word_row(CMD_READ, 8'd0, 8'd0, 8'd0));
        add_step(reg_row(REG_GRAYSCALE, 7'd0));
        add_step(reg_row(REG_NEGATE, 7'd7));
        add_step(word_row(CMD_LOAD, 8'd0, 8'd0, 8'd0));
        add_step(known_row(8'd255, 8'd255, 8'd255, 1'b1));
        add_step(reg_row(REG_FLATTEN, 7'd7));
        add_step(word_row(CMD_LOAD, 8'd255, 8'd255, 8'd255));
        add_step(known_row(8'd0, 8'd0, 8'd0, 1'b1));
        add_step(reg_row(REG_NEGATE, 7'd0));
        add_step(reg_row(REG_FLATTEN, 7'd0));
        add_step(reg_row(REG_CONTRAST, 7'd1));
        add_step(word_row(CMD_LOAD, 8'd127, 8'd128, 8'd255));
        add_step(known_row(8'd0, 8'd255, 8'd255, 1'b1));
        add_step(reg_row(REG_CONTRAST, 7'd0));
        add_step(reg_row(REG_NEGATE, 7'd5));
        add_step(reg_row(REG_FLATTEN, 7'd2));
        add_step(word_row(CMD_LOAD, 8'd10, 8'd20, 8'd30));
        add_step(word_row(CMD_READ, 8'd255, 8'd255, 8'd255));
        add_step(reg_row(REG_NEGATE, 7'd0));
        add_step(reg_row(REG_FLATTEN, 7'd0));
        add_step(reg_row(REG_IMAGE_WIDTH, 7'd2));
        add_step(reg_row(REG_IMAGE_HEIGHT, 7'd2));
        add_step(reg_row(REG_MIRROR_H, 7'd1));
        add_step(reg_row(REG_MIRROR_V, 7'd1));
        add_step(word_row(CMD_LOAD, 8'd1, 8'd2, 8'd3));
        add_step(word_row(CMD_LOAD, 8'd4, 8'd5, 8'd6));
        add_step(word_row(CMD_LOAD, 8'd7, 8'd8, 8'd9));
        add_step(word_row(CMD_LOAD, 8'd200, 8'd100, 8'd50));
        repeat (4) add_step(word_row(CMD_READ, 8'd17, 8'd34, 8'd51));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == ROW_REG) begin
                if (!drained) settle();
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
            end else begin
                fixed_pix.red = directed_steps[i].want_red;
                fixed_pix.green = directed_steps[i].want_green;
                fixed_pix.blue = directed_steps[i].want_blue;
                fixed_pix.last = directed_steps[i].want_last;
                send_word(directed_steps[i].cmd, directed_steps[i].red,
                          directed_steps[i].green, directed_steps[i].blue,
                          directed_steps[i].fixed, fixed_pix);
            end
        end

        // Random part: each phase sets the registers while idle, then mostly loads
        // a frame and reads it back; the rest is a random mix of words.
        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            settle();
            w = pick_dim();
            h = pick_dim();
            if (phase == 0) begin
                w = 7'd127;
                h = 7'd127;
            end else if (phase == 1) begin
                w = 7'd64;
                h = 7'd64;
            end else if (phase == 3) begin
                w = 7'd5;
                h = 7'd4;
            end
            case ($urandom_range(0, 2))
                0: tx_gap_pct = 0;
                1: tx_gap_pct = 10;
                default: tx_gap_pct = 35;
            endcase
            write_reg(REG_GRAYSCALE, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(REG_NEGATE, CFG_DATA_W'($urandom_range(0, 7)));
            write_reg(REG_FLATTEN,
                      CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0));
            write_reg(REG_CONTRAST, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(REG_MIRROR_H, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(REG_MIRROR_V, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, h);

            total = frame_total();
            n = (total > FRAME_CAP) ? FRAME_CAP : total;
            if (phase == 3 || $urandom_range(0, 4) != 0) begin
                repeat (n) random_word(CMD_LOAD);
                // Stall the result side long enough for the block to back up.
                if (phase == 3) hold_sink = 1'b1;
                repeat (n) random_word(CMD_READ);
            end else begin
                repeat (20) random_word($urandom_range(0, 1) ? CMD_READ : CMD_LOAD);
            end
            phase++;
        end

        settle();
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("rgb_frame_effects_mirror: match");
        end else begin
            $display("rgb_frame_effects_mirror: mismatch");
        end
        $finish;
    end

endmodule
